@@ src/sembq_pkg.sv @@
package sembq_pkg;

  localparam int CNT_W = 32;

  // operation codes on in_tuser[1:0]
  localparam logic [1:0] FN_SIGNAL = 2'd0;
  localparam logic [1:0] FN_WAIT   = 2'd1;
  localparam logic [1:0] FN_TRY    = 2'd2;
  localparam logic [1:0] FN_RESET  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BLOCKED     = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_WOULD_BLOCK = 3'd3;
  localparam logic [2:0] ST_IGNORED     = 3'd4;

  localparam logic [4:0] RESET_MIN_DEFAULT = 5'd9;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic is_zero;
    logic is_max;
  } cnt_flags_t;

endpackage

@@ src/sembq_ram.sv @@
module sembq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/sembq_cnt_unit.sv @@
// Shared count unit: one adder serves saturating increment and decrement.
module sembq_cnt_unit (
  input  sembq_pkg::cnt_op_t              op,
  input  logic [sembq_pkg::CNT_W-1:0]     cnt_in,
  output logic [sembq_pkg::CNT_W-1:0]     cnt_out,
  output sembq_pkg::cnt_flags_t           flags
);

  logic [sembq_pkg::CNT_W-1:0] addend;
  logic [sembq_pkg::CNT_W-1:0] sum;

  assign flags.is_zero = (cnt_in == '0);
  assign flags.is_max  = (cnt_in == '1);

  assign addend = (op == sembq_pkg::CNT_DEC) ? '1 : sembq_pkg::CNT_W'(1);
  assign sum    = cnt_in + addend;

  always_comb begin
    case (op)
      sembq_pkg::CNT_INC: cnt_out = flags.is_max  ? cnt_in : sum;
      sembq_pkg::CNT_DEC: cnt_out = flags.is_zero ? cnt_in : sum;
      sembq_pkg::CNT_CLR: cnt_out = '0;
      default:            cnt_out = cnt_in;
    endcase
  end

endmodule

@@ src/semaphore_bank_with_wait_queues_core.sv @@
// Channel | Direction | Payload
// in_     | slave     | tuser: func[1:0], bank[2]; tdata: sem_index[3:0], pid[19:4]
// out_    | master    | tuser: woken_valid; tdata: status[2:0], woken_pid[18:3]; tlast: last
// cfg_    | write     | cfg_wr_data: reset_min_index[4:0]
//
// Signal, wait and try-wait are accepted in S_IDLE, then make one pass through the
// count unit in S_EXEC. A signal that wakes a waiter adds one wait-queue RAM read.
// A reset that drains N waiters does one RAM read per waiter.
// rst_n is synchronous: counts and queue pointers clear, queue RAM is not cleared.
// A result waits in the output register; a stalled output holds the sequencer.
module semaphore_bank_with_wait_queues_core #(
  parameter int SEMS_PER_BANK = 16,
  parameter int QUEUE_DEPTH   = 32,
  parameter int PID_WIDTH     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sem_index[3:0], pid[19:4], zero pad
  input  logic [2:0]  in_tuser,   // func[1:0], bank[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[2:0], woken_pid[18:3], zero pad
  output logic        out_tuser,  // woken_valid
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int NUM_SEMS = 2 * SEMS_PER_BANK;
  localparam int SIDW     = $clog2(NUM_SEMS);
  localparam int QPW      = $clog2(QUEUE_DEPTH);
  localparam int QW       = (PID_WIDTH < 16) ? PID_WIDTH : 16;
  localparam int RAM_AW   = SIDW + QPW;
  localparam int RAM_D    = 2 ** RAM_AW;
  localparam logic [8:0]     SPB_W   = 9'(SEMS_PER_BANK);
  localparam logic [QPW-1:0] PTR_END = QPW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]      reset_min_r;
  logic [1:0]      req_func_r;
  logic [3:0]      req_idx_r;
  logic [SIDW-1:0] req_s_r;
  logic            req_in_range_r;
  logic [QW-1:0]   req_pid_r;

  logic [sembq_pkg::CNT_W-1:0] sem_count_r [NUM_SEMS];
  logic [QPW-1:0]              q_head_r    [NUM_SEMS];
  logic [QPW-1:0]              q_tail_r    [NUM_SEMS];
  logic [NUM_SEMS-1:0]         q_empty_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic                 out_wvalid_r;
  logic [QW-1:0]        out_wpid_r;
  logic                 out_last_r;

  logic                 emit;
  logic [2:0]           emit_status;
  logic                 emit_wvalid;
  logic                 emit_last;

  logic                 slot_free;
  logic                 in_acc;
  logic [3:0]           in_idx;
  logic [SIDW-1:0]      in_s;

  sembq_pkg::cnt_op_t   cnt_op;
  logic [sembq_pkg::CNT_W-1:0] cnt_cur;
  logic [sembq_pkg::CNT_W-1:0] cnt_new;
  sembq_pkg::cnt_flags_t       cnt_flags;

  logic [QPW-1:0]       head_cur, tail_cur, head_inc, tail_inc;
  logic                 empty_cur, full_cur;
  logic                 do_pop, do_push;

  logic                 ram_wr_en, ram_rd_en;
  logic [RAM_AW-1:0]    ram_wr_addr, ram_rd_addr;
  logic [QW-1:0]        ram_rd_data;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[3:0];
  assign in_s      = in_tuser[2] ? (SIDW'(SEMS_PER_BANK) + SIDW'(in_idx)) : SIDW'(in_idx);
  assign slot_free = !out_valid_r || out_tready;

  assign cnt_cur   = sem_count_r[req_s_r];
  assign head_cur  = q_head_r[req_s_r];
  assign tail_cur  = q_tail_r[req_s_r];
  assign empty_cur = q_empty_r[req_s_r];
  assign full_cur  = (head_cur == tail_cur) && !empty_cur;
  assign head_inc  = (head_cur == PTR_END) ? '0 : head_cur + QPW'(1);
  assign tail_inc  = (tail_cur == PTR_END) ? '0 : tail_cur + QPW'(1);

  assign ram_wr_en   = do_push;
  assign ram_wr_addr = {req_s_r, tail_cur};
  assign ram_rd_en   = do_pop;
  assign ram_rd_addr = {req_s_r, head_cur};

  sembq_cnt_unit u_cnt (
    .op      (cnt_op),
    .cnt_in  (cnt_cur),
    .cnt_out (cnt_new),
    .flags   (cnt_flags)
  );

  sembq_ram #(
    .WIDTH (QW),
    .DEPTH (RAM_D)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (req_pid_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_op      = sembq_pkg::CNT_HOLD;
    do_pop      = 1'b0;
    do_push     = 1'b0;
    emit        = 1'b0;
    emit_status = sembq_pkg::ST_OK;
    emit_wvalid = 1'b0;
    emit_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!req_in_range_r ||
            (req_func_r == sembq_pkg::FN_RESET && {1'b0, req_idx_r} < reset_min_r)) begin
          if (slot_free) begin
            emit        = 1'b1;
            emit_status = sembq_pkg::ST_IGNORED;
            state_nxt   = S_IDLE;
          end
        end else begin
          case (req_func_r)
            sembq_pkg::FN_SIGNAL: begin
              if (cnt_flags.is_zero && !empty_cur) begin
                do_pop    = 1'b1;
                state_nxt = S_POP;
              end else if (slot_free) begin
                cnt_op    = sembq_pkg::CNT_INC;
                emit      = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            sembq_pkg::FN_WAIT: begin
              if (slot_free) begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
                if (cnt_flags.is_zero && req_pid_r != '0) begin
                  if (full_cur) begin
                    emit_status = sembq_pkg::ST_FULL;
                  end else begin
                    do_push     = 1'b1;
                    emit_status = sembq_pkg::ST_BLOCKED;
                  end
                end else begin
                  // pid 0 on a zero count falls through here and changes nothing
                  cnt_op = sembq_pkg::CNT_DEC;
                end
              end
            end
            sembq_pkg::FN_TRY: begin
              if (slot_free) begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
                if (cnt_flags.is_zero) begin
                  emit_status = sembq_pkg::ST_WOULD_BLOCK;
                end else begin
                  cnt_op = sembq_pkg::CNT_DEC;
                end
              end
            end
            default: begin
              cnt_op = sembq_pkg::CNT_CLR;
              if (!empty_cur) begin
                do_pop    = 1'b1;
                state_nxt = S_POP;
              end else if (slot_free) begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
              end
            end
          endcase
        end
      end
      S_POP: begin
        // RAM data for the popped waiter is held until the output slot frees
        if (slot_free) begin
          emit        = 1'b1;
          emit_wvalid = 1'b1;
          emit_last   = (req_func_r != sembq_pkg::FN_RESET) || empty_cur;
          if (req_func_r == sembq_pkg::FN_RESET && !empty_cur) begin
            do_pop = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      reset_min_r <= sembq_pkg::RESET_MIN_DEFAULT;
      out_valid_r <= 1'b0;
      q_empty_r   <= '1;
      for (int i = 0; i < NUM_SEMS; i++) begin
        sem_count_r[i] <= '0;
        q_head_r[i]    <= '0;
        q_tail_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        reset_min_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cnt_op != sembq_pkg::CNT_HOLD) begin
        sem_count_r[req_s_r] <= cnt_new;
      end
      if (do_pop) begin
        q_head_r[req_s_r]  <= head_inc;
        q_empty_r[req_s_r] <= (head_inc == tail_cur);
      end
      if (do_push) begin
        q_tail_r[req_s_r]  <= tail_inc;
        q_empty_r[req_s_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_func_r     <= in_tuser[1:0];
      req_idx_r      <= in_idx;
      req_s_r        <= in_s;
      req_in_range_r <= ({5'b0, in_idx} < SPB_W);
      req_pid_r      <= in_tdata[QW+3:4];
    end
    if (emit) begin
      out_status_r <= emit_status;
      out_wvalid_r <= emit_wvalid;
      out_wpid_r   <= emit_wvalid ? ram_rd_data : '0;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, 16'(out_wpid_r), out_status_r};
  assign out_tuser  = out_wvalid_r;
  assign out_tlast  = out_last_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> !empty_cur)
    else $error("pop issued on an empty wait queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |-> !full_cur)
    else $error("push issued on a full wait queue");

  a_pop_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && !slot_free) |=> $stable(ram_rd_data))
    else $error("woken pid lost while output stalled");

  a_pop_enters_pop: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (state_r == S_POP))
    else $error("queue read not followed by a woken result");

endmodule
